// ===== hw/rtl/ydd_pkg.sv =====
// ----------------------------------------------------------------------------
// ydd_pkg
// Shared types, register indexes and helper functions of the YOLO detection
// decoder.
// ----------------------------------------------------------------------------
package ydd_pkg;

    localparam int MaxClasses   = 128;
    localparam int ElemWidth    = 19;
    localparam int PosWidth     = 8;
    localparam int ClassWidth   = 7;
    localparam int ScoreWidth   = 16;
    localparam int EdgeWidth    = 17;
    localparam int CenterWidth  = 28;
    localparam int HalfWidth    = 27;
    localparam int SumWidth     = 29;
    localparam int ProdWidth    = 44;
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 24;

    localparam logic [PosWidth-1:0] PosCenterX  = 8'd0;
    localparam logic [PosWidth-1:0] PosCenterY  = 8'd1;
    localparam logic [PosWidth-1:0] PosWidthEl  = 8'd2;
    localparam logic [PosWidth-1:0] PosHeightEl = 8'd3;
    localparam logic [PosWidth-1:0] PosFirstScore = 8'd4;
    localparam logic [PosWidth-1:0] PosLastMax  = 8'(3 + MaxClasses);

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_PAD_LEFT        = 3'd1,
        REG_PAD_TOP         = 3'd2,
        REG_INVERSE_SCALE   = 3'd3,
        REG_IMAGE_WIDTH     = 3'd4,
        REG_IMAGE_HEIGHT    = 3'd5,
        REG_CLASS_COUNT     = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [15:0] score_threshold;
        logic [11:0] pad_left;
        logic [11:0] pad_top;
        logic [23:0] inverse_scale;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [7:0]  class_count;
    } cfg_t;

    // Clamps a signed fixed-point edge to the range from zero to the image size.
    function automatic logic [EdgeWidth-1:0] clamp_edge(
        input logic signed [SumWidth-1:0] v,
        input logic [12:0]                limit
    );
        logic [EdgeWidth-1:0] hi;
        logic [EdgeWidth-1:0] res;
        hi = {limit, 4'b0000};
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({{(SumWidth-EdgeWidth){1'b0}}, hi})) begin
            res = hi;
        end else begin
            res = v[EdgeWidth-1:0];
        end
        return res;
    endfunction

    // Position of the last score of an anchor for a given class count.
    function automatic logic [PosWidth-1:0] last_position(input logic [7:0] count);
        logic [PosWidth-1:0] eff;
        if (count == 8'd0) begin
            eff = 8'd1;
        end else if (count > 8'(MaxClasses)) begin
            eff = 8'(MaxClasses);
        end else begin
            eff = count;
        end
        return eff + 8'd3;
    endfunction

endpackage

// ===== hw/rtl/ydd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ydd_cfg_regs
// Configuration register file of the YOLO detection decoder.
// ----------------------------------------------------------------------------
module ydd_cfg_regs
    import ydd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_SCORE_THRESHOLD: cfg_next.score_threshold = cfg_data[15:0];
                REG_PAD_LEFT:        cfg_next.pad_left        = cfg_data[11:0];
                REG_PAD_TOP:         cfg_next.pad_top         = cfg_data[11:0];
                REG_INVERSE_SCALE:   cfg_next.inverse_scale   = cfg_data[23:0];
                REG_IMAGE_WIDTH:     cfg_next.image_width     = cfg_data[12:0];
                REG_IMAGE_HEIGHT:    cfg_next.image_height    = cfg_data[12:0];
                REG_CLASS_COUNT:     cfg_next.class_count     = cfg_data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.score_threshold <= 16'd16384;
            cfg_reg.pad_left        <= 12'd0;
            cfg_reg.pad_top         <= 12'd0;
            cfg_reg.inverse_scale   <= 24'd65536;
            cfg_reg.image_width     <= 13'd640;
            cfg_reg.image_height    <= 13'd640;
            cfg_reg.class_count     <= 8'd80;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/yolo_detection_decode.sv =====
// ----------------------------------------------------------------------------
// yolo_detection_decode
// Decodes the detector output stream into boxes with a class and a score.
// ----------------------------------------------------------------------------
// The block takes one element per cycle and keeps taking elements while a
// detection waits at the output, unless the next detection is also ready,
// which stalls the input. Each anchor is 4 + class_count elements: cx, cy,
// w, h, then the class scores. A detection reaches the output register
// through an input register, the box multiplier with its product register,
// and the update of the box edges and the running best score. Anchors
// without a qualifying class or with a box under one pixel give no request.
module yolo_detection_decode
    import ydd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             s_tdata,   // element[18:0], zero fill
    input  logic [0:0]              s_tuser,   // frame_start[0]
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [95:0]             m_tdata,   // label[6:0], confidence[22:7],
                                               // box_left[39:23], box_top[56:40],
                                               // box_width[73:57], box_height[90:74]
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data
);

    cfg_t cfg;

    ydd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Position tracking at the input.
    logic [PosWidth-1:0] pos_reg, pos_next;
    logic [PosWidth-1:0] in_pos;
    logic                in_last;
    logic                s_fire;

    // Stage one: registered element.
    logic                        s1_valid_reg, s1_valid_next;
    logic signed [ElemWidth-1:0] s1_elem_reg;
    logic [PosWidth-1:0]         s1_pos_reg;
    logic                        s1_last_reg;

    // Stage two: registered product and saturated score.
    logic                        s2_valid_reg, s2_valid_next;
    logic signed [ProdWidth-1:0] s2_prod_reg;
    logic [ScoreWidth-1:0]       s2_score_reg;
    logic [PosWidth-1:0]         s2_pos_reg;
    logic                        s2_last_reg;

    // Anchor state.
    logic signed [CenterWidth-1:0] center_x_reg, center_y_reg;
    logic [EdgeWidth-1:0]          left_reg, right_reg, top_reg, bottom_reg;
    logic [ScoreWidth-1:0]         top_score_reg, top_score_next;
    logic [ClassWidth-1:0]         best_class_reg, best_class_next;
    logic                          have_best_reg, have_best_next;

    logic                    m_tvalid_reg;
    logic [95:0]             m_tdata_reg;

    logic                    s1_move, s2_fire, s2_free, s1_free, out_free;
    logic                    emit;

    logic signed [19:0]          mul_op;
    logic signed [ProdWidth-1:0] prod_full;
    logic [ScoreWidth-1:0]       score_sat;

    logic signed [CenterWidth-1:0] center;
    logic signed [HalfWidth-1:0]   half;
    logic signed [SumWidth-1:0]    sum_lo_x, sum_hi_x, sum_lo_y, sum_hi_y;
    logic [EdgeWidth-1:0]          clamp_lo, clamp_hi;
    logic signed [EdgeWidth:0]     box_w, box_h;
    logic                          size_ok;

    assign in_pos  = s_tuser[0] ? PosCenterX : pos_reg;
    assign in_last = (in_pos >= PosFirstScore) && (in_pos >= last_position(cfg.class_count));
    assign pos_next = in_last ? PosCenterX : in_pos + 8'd1;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s2_fire  = s2_valid_reg && (!emit || out_free);
    assign s2_free  = !s2_valid_reg || s2_fire;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_tready = s1_free;
    assign s_fire   = s_tvalid && s_tready;

    assign s1_valid_next = s_fire || (s1_valid_reg && !s2_free);
    assign s2_valid_next = s1_move || (s2_valid_reg && !s2_fire);

    always_comb begin
        case (s1_pos_reg)
            PosCenterX: mul_op = {s1_elem_reg[ElemWidth-1], s1_elem_reg}
                                 - $signed({4'b0000, cfg.pad_left, 4'b0000});
            PosCenterY: mul_op = {s1_elem_reg[ElemWidth-1], s1_elem_reg}
                                 - $signed({4'b0000, cfg.pad_top, 4'b0000});
            default:    mul_op = {s1_elem_reg[ElemWidth-1], s1_elem_reg};
        endcase
    end

    assign prod_full = mul_op * $signed({1'b0, cfg.inverse_scale});

    always_comb begin
        if (s1_elem_reg[ElemWidth-1]) begin
            score_sat = '0;
        end else if (s1_elem_reg[17:16] != 2'b00) begin
            score_sat = '1;
        end else begin
            score_sat = s1_elem_reg[15:0];
        end
    end

    assign center = s2_prod_reg[ProdWidth-1:16];
    assign half   = s2_prod_reg[ProdWidth-1:17];

    assign sum_lo_x = SumWidth'(center_x_reg) - SumWidth'(half);
    assign sum_hi_x = SumWidth'(center_x_reg) + SumWidth'(half);
    assign sum_lo_y = SumWidth'(center_y_reg) - SumWidth'(half);
    assign sum_hi_y = SumWidth'(center_y_reg) + SumWidth'(half);

    always_comb begin
        if (s2_pos_reg == PosWidthEl) begin
            clamp_lo = clamp_edge(sum_lo_x, cfg.image_width);
            clamp_hi = clamp_edge(sum_hi_x, cfg.image_width);
        end else begin
            clamp_lo = clamp_edge(sum_lo_y, cfg.image_height);
            clamp_hi = clamp_edge(sum_hi_y, cfg.image_height);
        end
    end

    always_comb begin
        top_score_next  = top_score_reg;
        best_class_next = best_class_reg;
        have_best_next  = have_best_reg;
        if (s2_pos_reg == PosFirstScore) begin
            top_score_next  = cfg.score_threshold;
            best_class_next = '0;
            have_best_next  = 1'b0;
        end
        if (s2_score_reg > top_score_next) begin
            top_score_next  = s2_score_reg;
            best_class_next = ClassWidth'(s2_pos_reg - PosFirstScore);
            have_best_next  = 1'b1;
        end
    end

    assign box_w   = $signed({1'b0, right_reg}) - $signed({1'b0, left_reg});
    assign box_h   = $signed({1'b0, bottom_reg}) - $signed({1'b0, top_reg});
    assign size_ok = !box_w[EdgeWidth] && (box_w[EdgeWidth-1:4] != '0)
                  && !box_h[EdgeWidth] && (box_h[EdgeWidth-1:4] != '0);
    assign emit    = s2_last_reg && (s2_pos_reg >= PosFirstScore)
                  && have_best_next && size_ok;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_elem_reg <= s_tdata[ElemWidth-1:0];
            s1_pos_reg  <= in_pos;
            s1_last_reg <= in_last;
        end
        if (s1_move) begin
            s2_prod_reg  <= prod_full;
            s2_score_reg <= score_sat;
            s2_pos_reg   <= s1_pos_reg;
            s2_last_reg  <= s1_last_reg;
        end
        if (s2_fire && emit) begin
            m_tdata_reg <= {5'b00000, box_h[EdgeWidth-1:0], box_w[EdgeWidth-1:0],
                            top_reg, left_reg, top_score_next, best_class_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            top_reg        <= '0;
            bottom_reg     <= '0;
            top_score_reg  <= '0;
            best_class_reg <= '0;
            have_best_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            if (s_fire) begin
                pos_reg <= pos_next;
            end
            if (s2_fire && emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (s2_fire) begin
                case (s2_pos_reg)
                    PosCenterX: center_x_reg <= center;
                    PosCenterY: center_y_reg <= center;
                    PosWidthEl: begin
                        left_reg  <= clamp_lo;
                        right_reg <= clamp_hi;
                    end
                    PosHeightEl: begin
                        top_reg    <= clamp_lo;
                        bottom_reg <= clamp_hi;
                    end
                    default: begin
                        top_score_reg  <= top_score_next;
                        best_class_reg <= best_class_next;
                        have_best_reg  <= have_best_next;
                    end
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= PosLastMax)
        else $error("Element position ran past the last score.");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(s2_valid_reg && s2_last_reg))
        else $error("Detection appeared without a finished anchor.");

    a_out_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[73:57] >= 17'd16 && m_tdata_reg[90:74] >= 17'd16))
        else $error("Detection smaller than one pixel.");

endmodule

// ===== tb/sv/tb_yolo_detection_decode.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_yolo_detection_decode
// Streams anchors of box values and class scores into the decoder and checks
// every detection against a predictor that runs beside the stream. A short
// table of directed anchors comes first, followed by random phases with
// changing register settings and idle patterns on both stream sides.
// ----------------------------------------------------------------------------
module tb_yolo_detection_decode;

    import ydd_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [CfgIdxWidth-1:0] REG_UNUSED_SLOT = 3'd7;

    typedef struct packed {
        logic [16:0] box_height;
        logic [16:0] box_width;
        logic [16:0] box_top;
        logic [16:0] box_left;
        logic [15:0] confidence;
        logic [6:0]  label;
    } detection_t;

    typedef enum logic [0:0] {
        ROW_ELEMENT,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic                 frame_start;
        logic [CfgIdxWidth-1:0] reg_sel;
        logic [23:0]          value;
        logic                 typed;
        detection_t           want;
    } stim_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [23:0]             s_tdata;
    logic [0:0]              s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [95:0]             m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;

    cfg_t shadow_cfg = '{
        score_threshold: 16'd16384,
        pad_left:        12'd0,
        pad_top:         12'd0,
        inverse_scale:   24'd65536,
        image_width:     13'd640,
        image_height:    13'd640,
        class_count:     8'd80
    };

    logic [7:0]         anchor_pos  = '0;
    logic signed [31:0] center_x    = '0;
    logic signed [31:0] center_y    = '0;
    logic [16:0]        left_edge   = '0;
    logic [16:0]        right_edge  = '0;
    logic [16:0]        top_edge    = '0;
    logic [16:0]        bottom_edge = '0;
    logic [15:0]        lead_score  = '0;
    logic [6:0]         best_class  = '0;
    logic               best_valid  = 1'b0;

    detection_t  pending_detections[$];
    int          fail_count      = 0;
    int          total_items     = 0;
    int          send_idle_pct   = 0;
    int          stall_pct       = 0;
    int unsigned cycle_count     = 0;

    yolo_detection_decode uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("yolo_detection_decode: mismatch");
            $finish;
        end
    end

    function automatic detection_t make_detection(input int cls, input int conf,
                                                  input int left, input int top,
                                                  input int wid, input int hgt);
        detection_t d;
        d.label      = 7'(cls);
        d.confidence = 16'(conf);
        d.box_left   = 17'(left);
        d.box_top    = 17'(top);
        d.box_width  = 17'(wid);
        d.box_height = 17'(hgt);
        return d;
    endfunction

    function automatic stim_row_t item_row(input logic fs, input int value);
        return '{ROW_ELEMENT, fs, 3'd0, 24'(value), 1'b0, '0};
    endfunction

    function automatic stim_row_t checked_row(input logic fs, input int value,
                                              input detection_t want);
        return '{ROW_ELEMENT, fs, 3'd0, 24'(value), 1'b1, want};
    endfunction

    function automatic stim_row_t reg_row(input logic [CfgIdxWidth-1:0] idx, input int value);
        return '{ROW_CONFIG, 1'b0, idx, 24'(value), 1'b0, '0};
    endfunction

    stim_row_t directed_rows [0:34] = '{
        reg_row(REG_CLASS_COUNT, 1),
        // Box covering the whole image, score above the range.
        item_row(1'b1, 5120), item_row(1'b0, 5120),
        item_row(1'b0, 20480), item_row(1'b0, 20480),
        checked_row(1'b0, 262143, make_detection(0, 65535, 0, 0, 10240, 10240)),
        // Negative width and a score below the range.
        item_row(1'b0, 1600), item_row(1'b0, 1600),
        item_row(1'b0, -320), item_row(1'b0, 320), item_row(1'b0, -262144),
        reg_row(REG_INVERSE_SCALE, 0),
        item_row(1'b1, -262144), item_row(1'b0, 262143),
        item_row(1'b0, 262143), item_row(1'b0, -262144), item_row(1'b0, 60000),
        reg_row(REG_INVERSE_SCALE, 65536),
        reg_row(REG_CLASS_COUNT, 3),
        // The first class only equals the threshold; a tie keeps the lower class.
        item_row(1'b1, 1600), item_row(1'b0, 1600),
        item_row(1'b0, 320), item_row(1'b0, 320),
        item_row(1'b0, 16384), item_row(1'b0, 20000),
        checked_row(1'b0, 20000, make_detection(1, 20000, 1440, 1440, 320, 320)),
        reg_row(REG_CLASS_COUNT, 5),
        item_row(1'b1, 1600), item_row(1'b0, 1600),
        item_row(1'b0, 320), item_row(1'b0, 320),
        item_row(1'b0, 1000), item_row(1'b0, 40000),
        // The class count shrinks below the current position mid-anchor.
        reg_row(REG_CLASS_COUNT, 1),
        checked_row(1'b0, 50000, make_detection(2, 50000, 1440, 1440, 320, 320))
    };

    function automatic int unsigned classes_in_use();
        int unsigned count;
        count = shadow_cfg.class_count;
        if (count < 1) count = 1;
        if (count > MaxClasses) count = MaxClasses;
        return count;
    endfunction

    function automatic logic [16:0] clamp_to_image(input longint v, input logic [12:0] limit);
        longint hi;
        hi = longint'(limit) * 16;
        if (v < 0) return '0;
        if (v > hi) return 17'(hi);
        return 17'(v);
    endfunction

    function automatic bit decode_element(input logic frame_start, input logic [18:0] raw,
                                          output detection_t found);
        longint      e;
        longint      half;
        longint      span_w;
        longint      span_h;
        logic [15:0] score;
        bit          emit;
        e     = longint'($signed(raw));
        found = '0;
        emit  = 1'b0;
        if (frame_start) anchor_pos = '0;
        case (anchor_pos)
            PosCenterX: begin
                center_x = 32'(((e - longint'(shadow_cfg.pad_left) * 16)
                                * longint'(shadow_cfg.inverse_scale)) >>> 16);
            end
            PosCenterY: begin
                center_y = 32'(((e - longint'(shadow_cfg.pad_top) * 16)
                                * longint'(shadow_cfg.inverse_scale)) >>> 16);
            end
            PosWidthEl: begin
                half       = (e * longint'(shadow_cfg.inverse_scale)) >>> 17;
                left_edge  = clamp_to_image(longint'(center_x) - half, shadow_cfg.image_width);
                right_edge = clamp_to_image(longint'(center_x) + half, shadow_cfg.image_width);
            end
            PosHeightEl: begin
                half        = (e * longint'(shadow_cfg.inverse_scale)) >>> 17;
                top_edge    = clamp_to_image(longint'(center_y) - half, shadow_cfg.image_height);
                bottom_edge = clamp_to_image(longint'(center_y) + half,
                                             shadow_cfg.image_height);
            end
            default: begin
                score = (e < 0) ? 16'd0 : ((e > 65535) ? 16'hFFFF : e[15:0]);
                if (anchor_pos == PosFirstScore) begin
                    lead_score = shadow_cfg.score_threshold;
                    best_class = '0;
                    best_valid = 1'b0;
                end
                if (score > lead_score) begin
                    lead_score = score;
                    best_class = 7'(anchor_pos - PosFirstScore);
                    best_valid = 1'b1;
                end
                if (int'(anchor_pos) >= 3 + int'(classes_in_use())) begin
                    span_w = longint'(right_edge) - longint'(left_edge);
                    span_h = longint'(bottom_edge) - longint'(top_edge);
                    emit   = best_valid && span_w >= 16 && span_h >= 16;
                    found.label      = best_class;
                    found.confidence = lead_score;
                    found.box_left   = left_edge;
                    found.box_top    = top_edge;
                    found.box_width  = 17'(span_w);
                    found.box_height = 17'(span_h);
                    // The increment below wraps this to the first position.
                    anchor_pos = 8'hFF;
                end
            end
        endcase
        anchor_pos = anchor_pos + 8'd1;
        return emit;
    endfunction

    function automatic void apply_register(input logic [CfgIdxWidth-1:0] idx,
                                           input logic [23:0] value);
        case (idx)
            REG_SCORE_THRESHOLD: shadow_cfg.score_threshold = value[15:0];
            REG_PAD_LEFT:        shadow_cfg.pad_left        = value[11:0];
            REG_PAD_TOP:         shadow_cfg.pad_top         = value[11:0];
            REG_INVERSE_SCALE:   shadow_cfg.inverse_scale   = value[23:0];
            REG_IMAGE_WIDTH:     shadow_cfg.image_width     = value[12:0];
            REG_IMAGE_HEIGHT:    shadow_cfg.image_height    = value[12:0];
            REG_CLASS_COUNT:     shadow_cfg.class_count     = value[7:0];
            default: ;
        endcase
    endfunction

    task automatic push_element(input logic fs, input logic [18:0] value,
                                input bit use_typed, input detection_t typed_det);
        detection_t predicted;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, value};
        s_tuser  <= fs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        total_items++;
        if (decode_element(fs, value, predicted) || use_typed) begin
            pending_detections.insert(pending_detections.size(),
                                      use_typed ? typed_det : predicted);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_detections.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CfgIdxWidth-1:0] idx, input logic [23:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_register(idx, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        detection_t got;
        detection_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = detection_t'(m_tdata[90:0]);
            if (pending_detections.size() == 0) begin
                $error("detection: expected none, got label %0d", got.label);
                fail_count++;
            end else begin
                want = pending_detections.pop_front();
                compare_field("label", want.label, got.label);
                compare_field("confidence", want.confidence, got.confidence);
                compare_field("box_left", want.box_left, got.box_left);
                compare_field("box_top", want.box_top, got.box_top);
                compare_field("box_width", want.box_width, got.box_width);
                compare_field("box_height", want.box_height, got.box_height);
            end
        end
    end

    function automatic logic [18:0] pick_center(input logic [11:0] pad);
        if ($urandom_range(0, 15) == 0) return 19'($urandom);
        return 19'(16 * int'(pad) + $urandom_range(0, 16 * 700));
    endfunction

    function automatic logic [18:0] pick_size();
        if ($urandom_range(0, 15) == 0) return 19'($urandom);
        return 19'($urandom_range(0, 16 * 400));
    endfunction

    function automatic logic [18:0] pick_score();
        if ($urandom_range(0, 15) == 0) return 19'($urandom);
        return 19'($urandom_range(0, 65535));
    endfunction

    function automatic cfg_t pick_settings(input int phase);
        cfg_t s;
        if (phase == 0) begin
            s = '{16'hFFFF, 12'd0, 12'd0, 24'd0, 13'd0, 13'd0, 8'd0};
        end else if (phase == 1) begin
            s = '{16'd0, 12'hFFF, 12'hFFF, 24'hFFFFFF, 13'h1FFF, 13'h1FFF, 8'hFF};
        end else if (phase % 5 == 4) begin
            s = '{16'($urandom), 12'($urandom), 12'($urandom), 24'($urandom),
                  13'($urandom), 13'($urandom), 8'($urandom)};
        end else begin
            s.score_threshold = 16'($urandom_range(0, 40000));
            s.pad_left        = 12'($urandom_range(0, 100));
            s.pad_top         = 12'($urandom_range(0, 100));
            s.inverse_scale   = 24'($urandom_range(32768, 131072));
            s.image_width     = 13'($urandom_range(200, 1920));
            s.image_height    = 13'($urandom_range(200, 1920));
            s.class_count     = 8'($urandom_range(1, 12));
        end
        return s;
    endfunction

    task automatic send_anchor(inout int sent, inout bit resync);
        int          span;
        int          cut;
        int          roll;
        bit          lead;
        logic [18:0] value;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            push_element(1'($urandom), 19'($urandom), 1'b0, '0);
            sent++;
            resync = 1'b1;
            return;
        end
        span = 4 + int'(classes_in_use());
        cut  = (roll < 13) ? $urandom_range(1, span - 1) : span;
        lead = resync || ($urandom_range(0, 7) == 0);
        for (int k = 0; k < cut; k++) begin
            case (k)
                0:       value = pick_center(shadow_cfg.pad_left);
                1:       value = pick_center(shadow_cfg.pad_top);
                2, 3:    value = pick_size();
                default: value = pick_score();
            endcase
            push_element((k == 0) ? lead : 1'b0, value, 1'b0, '0);
        end
        sent  += cut;
        resync = (cut != span);
    endtask

    task automatic run_phase(input int phase);
        cfg_t settings;
        int   sent;
        bit   resync;
        bit   paused;
        settings = pick_settings(phase);
        case (phase % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 77; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 77; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
        endcase
        write_register(REG_SCORE_THRESHOLD, 24'(settings.score_threshold));
        write_register(REG_PAD_LEFT, 24'(settings.pad_left));
        write_register(REG_PAD_TOP, 24'(settings.pad_top));
        write_register(REG_INVERSE_SCALE, settings.inverse_scale);
        write_register(REG_IMAGE_WIDTH, 24'(settings.image_width));
        write_register(REG_IMAGE_HEIGHT, 24'(settings.image_height));
        write_register(REG_CLASS_COUNT, 24'(settings.class_count));
        if (phase == 0) write_register(REG_UNUSED_SLOT, 24'($urandom));
        sent   = 0;
        resync = 1'b1;
        paused = 1'b0;
        while (sent < 100) begin
            if (phase == 2 && !paused && sent >= 50) begin
                wait_drained();
                paused = 1'b1;
            end
            send_anchor(sent, resync);
        end
        wait_drained();
    endtask

    initial begin
        int phase;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                wait_drained();
                write_register(directed_rows[i].reg_sel, directed_rows[i].value);
            end else begin
                push_element(directed_rows[i].frame_start, directed_rows[i].value[18:0],
                             directed_rows[i].typed, directed_rows[i].want);
            end
        end
        wait_drained();

        phase = 0;
        while (total_items < 600) begin
            run_phase(phase);
            phase++;
        end
        wait_drained();

        if (fail_count == 0) begin
            $display("yolo_detection_decode: match");
        end else begin
            $display("yolo_detection_decode: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ydd_pkg.sv
hw/rtl/ydd_cfg_regs.sv
hw/rtl/yolo_detection_decode.sv
tb/sv/tb_yolo_detection_decode.sv
